>>> sv/tlc_pkg.sv
`timescale 1ns / 1ps
package tlc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam int IN_W       = 32;
  localparam int OUT_W      = 16;
  localparam int STAMP_W    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FIFO_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_INDEX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_WAYS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_ENABLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_INDEX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS     = 3'd6;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE,
    S_L1_WAIT, S_L1_EVAL, S_L1_COMMIT,
    S_L2W_INIT, S_L2W_WAIT, S_L2W_EVAL, S_L2W_COMMIT,
    S_L2R_INIT, S_L2R_WAIT, S_L2R_EVAL, S_L2R_COMMIT,
    S_DONE
  } st_t;

  typedef struct packed {
    logic init;
    logic eval;
    logic commit;
    logic clr;
  } lvl_cmd_t;

  typedef struct packed {
    logic last;
    logic hit;
    logic vic_dirty;
    logic clr_done;
  } lvl_sts_t;

  typedef struct packed {
    logic     accept;
    lvl_cmd_t l1;
    lvl_cmd_t l2;
    logic     l2_wr_pass;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    lvl_sts_t l1;
    lvl_sts_t l2;
    logic     l2_enable;
  } dp_sts_t;

  function automatic logic [3:0] eff_ib(input logic [3:0] req, input logic [3:0] maxb);
    return (req > maxb) ? maxb : req;
  endfunction

endpackage

>>> sv/tlc_ram.sv
`timescale 1ns / 1ps
module tlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/tlc_level.sv
`timescale 1ns / 1ps
module tlc_level import tlc_pkg::*; #(
  parameter int SETS   = 256,
  parameter int MAXW   = 32,
  parameter int ADDR_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lvl_cmd_t          cmd,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic              is_write_i,
  input  logic [2:0]        offset_bits_i,
  input  logic [3:0]        index_bits_i,
  input  logic [5:0]        ways_i,
  input  logic              fifo_mode_i,
  output lvl_sts_t          sts,
  output logic [ADDR_W-1:0] vic_tag_o
);

  localparam int DEPTH  = SETS * MAXW;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WW     = $clog2(MAXW + 1);
  localparam int WIW    = (MAXW > 1) ? $clog2(MAXW) : 1;
  localparam int IB_MAX = $clog2(SETS + 1) - 1;
  localparam int LW     = ADDR_W + 2 + STAMP_W;

  logic [3:0]        ib;
  logic [ADDR_W-1:0] set_w, tag_w;
  logic [6:0]        ways_ext;
  logic [WW-1:0]     ways_eff;

  logic [SW-1:0]      set_r;
  logic [ADDR_W-1:0]  tag_r;
  logic               write_r;
  logic [WW-1:0]      ways_r, way_r;
  logic [STAMP_W-1:0] count_r;
  logic               hit_r, hit_dirty_r;
  logic [STAMP_W-1:0] hit_stamp_r;
  logic               inv_found_r;
  logic [WW-1:0]      inv_way_r, min_way_r;
  logic [STAMP_W-1:0] min_stamp_r;
  logic               min_dirty_r;
  logic [ADDR_W-1:0]  min_tag_r;
  logic [AW-1:0]      clr_addr_r;
  logic               clr_done_r;

  logic [LW-1:0]      rdata, wdata;
  logic               l_valid, l_dirty, hit_now, last_now, clr_act, we;
  logic [ADDR_W-1:0]  l_tag;
  logic [STAMP_W-1:0] l_stamp;
  logic [AW-1:0]      base, raddr, waddr;
  logic [WW-1:0]      cway;

  assign ib       = eff_ib(index_bits_i, 4'(IB_MAX));
  assign set_w    = (addr_i >> offset_bits_i) & ((ADDR_W'(1) << ib) - ADDR_W'(1));
  assign tag_w    = addr_i >> ({2'b0, offset_bits_i} + {1'b0, ib});
  assign ways_ext = (ways_i == 6'd0) ? 7'd1 :
                    (({1'b0, ways_i}) > 7'(MAXW)) ? 7'(MAXW) : {1'b0, ways_i};
  assign ways_eff = WW'(ways_ext);

  assign l_valid  = rdata[LW-1];
  assign l_dirty  = rdata[LW-2];
  assign l_tag    = rdata[ADDR_W+STAMP_W-1:STAMP_W];
  assign l_stamp  = rdata[STAMP_W-1:0];
  assign hit_now  = l_valid && (l_tag == tag_r);
  assign last_now = hit_now || ((way_r + WW'(1)) == ways_r);

  assign base  = AW'(AW'(set_r) * AW'(MAXW));
  assign raddr = base + AW'(way_r[WIW-1:0]);
  assign cway  = hit_r ? way_r : (inv_found_r ? inv_way_r : min_way_r);

  always_comb begin
    if (hit_r) begin
      wdata = {1'b1, hit_dirty_r | write_r, tag_r, fifo_mode_i ? hit_stamp_r : count_r};
    end else begin
      wdata = {1'b1, write_r, tag_r, count_r};
    end
  end

  assign clr_act = cmd.clr && !clr_done_r;
  assign we      = clr_act || cmd.commit;
  assign waddr   = clr_act ? clr_addr_r : base + AW'(cway[WIW-1:0]);

  tlc_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (clr_act ? '0 : wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_done_r <= 1'b0;
      count_r    <= '0;
      way_r      <= '0;
      hit_r      <= 1'b0;
      inv_found_r <= 1'b0;
    end else begin
      if (clr_act) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          clr_done_r <= 1'b1;
        end
      end
      if (cmd.init) begin
        count_r     <= (count_r == '1) ? count_r : count_r + STAMP_W'(1);
        way_r       <= '0;
        hit_r       <= 1'b0;
        inv_found_r <= 1'b0;
      end else if (cmd.eval) begin
        if (hit_now) begin
          hit_r <= 1'b1;
        end else if (!l_valid && !inv_found_r) begin
          inv_found_r <= 1'b1;
        end
        if (!last_now) begin
          way_r <= way_r + WW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      set_r   <= SW'(set_w);
      tag_r   <= tag_w;
      write_r <= is_write_i;
      ways_r  <= ways_eff;
    end else if (cmd.eval) begin
      if (hit_now) begin
        hit_dirty_r <= l_dirty;
        hit_stamp_r <= l_stamp;
      end else begin
        if (!l_valid && !inv_found_r) begin
          inv_way_r <= way_r;
        end
        if ((way_r == '0) || (l_stamp < min_stamp_r)) begin
          min_way_r   <= way_r;
          min_stamp_r <= l_stamp;
          min_dirty_r <= l_dirty;
          min_tag_r   <= l_tag;
        end
      end
    end
  end

  assign sts.last      = last_now;
  assign sts.hit       = hit_r;
  assign sts.vic_dirty = !hit_r && !inv_found_r && min_dirty_r;
  assign sts.clr_done  = clr_done_r;
  assign vic_tag_o     = min_tag_r;

endmodule

>>> sv/tlc_datapath.sv
`timescale 1ns / 1ps
module tlc_datapath import tlc_pkg::*; #(
  parameter int L1_SETS = 256,
  parameter int L2_SETS = 1024,
  parameter int MAXW    = 32,
  parameter int ADDR_W  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic [IN_W-1:0]       in_addr,
  input  logic                  in_op,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_val,
  output logic [OUT_W-1:0]      out_data
);

  localparam int IB1_MAX = $clog2(L1_SETS + 1) - 1;

  logic       fifo_mode_r, l2_enable_r;
  logic [2:0] offset_bits_r;
  logic [3:0] l1_index_r, l2_index_r;
  logic [5:0] l1_ways_r, l2_ways_r;

  logic [ADDR_W-1:0] addr_r, in_addr_w, l1_vic_tag, l2_vic_tag, set1, offv, back, l2_addr;
  logic [3:0]        ib1;
  logic [4:0]        shamt;
  logic              hit_r, wb1_r, rd_r, rdh_r, wr_r, wrh_r;
  logic [1:0]        wb2_r;
  logic [2:0]        traffic;
  logic [OUT_W-1:0]  out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_mode_r   <= 1'b0;
      offset_bits_r <= 3'd5;
      l1_index_r    <= 4'd6;
      l1_ways_r     <= 6'd2;
      l2_enable_r   <= 1'b0;
      l2_index_r    <= 4'd8;
      l2_ways_r     <= 6'd4;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FIFO_MODE:   fifo_mode_r   <= cfg_val[0];
        CFG_OFFSET_BITS: offset_bits_r <= cfg_val[2:0];
        CFG_L1_INDEX:    l1_index_r    <= cfg_val[3:0];
        CFG_L1_WAYS:     l1_ways_r     <= cfg_val;
        CFG_L2_ENABLE:   l2_enable_r   <= cfg_val[0];
        CFG_L2_INDEX:    l2_index_r    <= cfg_val[3:0];
        CFG_L2_WAYS:     l2_ways_r     <= cfg_val;
        default: ;
      endcase
    end
  end

  assign in_addr_w = ADDR_W'(in_addr);
  assign ib1   = eff_ib(l1_index_r, 4'(IB1_MAX));
  assign shamt = {1'b0, ib1} + {2'b0, offset_bits_r};
  assign set1  = (addr_r >> offset_bits_r) & ((ADDR_W'(1) << ib1) - ADDR_W'(1));
  assign offv  = addr_r & ((ADDR_W'(1) << offset_bits_r) - ADDR_W'(1));
  assign back  = (l1_vic_tag << shamt) | (set1 << offset_bits_r) | offv;
  assign l2_addr = cmd.l2_wr_pass ? back : addr_r;

  tlc_level #(.SETS(L1_SETS), .MAXW(MAXW), .ADDR_W(ADDR_W)) u_l1 (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd.l1),
    .addr_i        (in_addr_w),
    .is_write_i    (in_op),
    .offset_bits_i (offset_bits_r),
    .index_bits_i  (l1_index_r),
    .ways_i        (l1_ways_r),
    .fifo_mode_i   (fifo_mode_r),
    .sts           (sts.l1),
    .vic_tag_o     (l1_vic_tag)
  );

  tlc_level #(.SETS(L2_SETS), .MAXW(MAXW), .ADDR_W(ADDR_W)) u_l2 (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd.l2),
    .addr_i        (l2_addr),
    .is_write_i    (cmd.l2_wr_pass),
    .offset_bits_i (offset_bits_r),
    .index_bits_i  (l2_index_r),
    .ways_i        (l2_ways_r),
    .fifo_mode_i   (fifo_mode_r),
    .sts           (sts.l2),
    .vic_tag_o     (l2_vic_tag)
  );

  assign sts.l2_enable = l2_enable_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_r <= in_addr_w;
      rd_r   <= 1'b0;
      rdh_r  <= 1'b0;
      wr_r   <= 1'b0;
      wrh_r  <= 1'b0;
      wb2_r  <= 2'd0;
    end
    if (cmd.l1.commit) begin
      hit_r <= sts.l1.hit;
      wb1_r <= sts.l1.vic_dirty;
    end
    if (cmd.l2.commit) begin
      if (cmd.l2_wr_pass) begin
        wr_r  <= 1'b1;
        wrh_r <= sts.l2.hit;
      end else begin
        rd_r  <= 1'b1;
        rdh_r <= sts.l2.hit;
      end
      wb2_r <= wb2_r + {1'b0, sts.l2.vic_dirty};
    end
    if (cmd.load_out) begin
      out_r <= OUT_W'({traffic, wb2_r, wrh_r, wr_r, rdh_r, rd_r, wb1_r, hit_r});
    end
  end

  assign traffic = l2_enable_r ?
                   ({2'b0, rd_r & ~rdh_r} + {2'b0, wr_r & ~wrh_r} + {1'b0, wb2_r}) :
                   ({2'b0, ~hit_r} + {2'b0, wb1_r});

  assign out_data = out_r;

endmodule

>>> sv/tlc_ctrl.sv
`timescale 1ns / 1ps
module tlc_ctrl import tlc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_accept,
  output logic    in_ready,
  input  logic    out_ready,
  output logic    out_valid,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  st_t  state_r, state_nxt;
  logic out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:      if (sts.l1.clr_done && sts.l2.clr_done) state_nxt = S_IDLE;
      S_IDLE:       if (in_accept) state_nxt = S_L1_WAIT;
      S_L1_WAIT:    state_nxt = S_L1_EVAL;
      S_L1_EVAL:    state_nxt = sts.l1.last ? S_L1_COMMIT : S_L1_WAIT;
      S_L1_COMMIT: begin
        if (sts.l1.hit || !sts.l2_enable) state_nxt = S_DONE;
        else if (sts.l1.vic_dirty)        state_nxt = S_L2W_INIT;
        else                              state_nxt = S_L2R_INIT;
      end
      S_L2W_INIT:   state_nxt = S_L2W_WAIT;
      S_L2W_WAIT:   state_nxt = S_L2W_EVAL;
      S_L2W_EVAL:   state_nxt = sts.l2.last ? S_L2W_COMMIT : S_L2W_WAIT;
      S_L2W_COMMIT: state_nxt = S_L2R_INIT;
      S_L2R_INIT:   state_nxt = S_L2R_WAIT;
      S_L2R_WAIT:   state_nxt = S_L2R_EVAL;
      S_L2R_EVAL:   state_nxt = sts.l2.last ? S_L2R_COMMIT : S_L2R_WAIT;
      S_L2R_COMMIT: state_nxt = S_DONE;
      S_DONE:       if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:      state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.l1.clr = 1'b1;
        cmd.l2.clr = 1'b1;
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_accept;
        cmd.l1.init = in_accept;
      end
      S_L1_EVAL:    cmd.l1.eval = 1'b1;
      S_L1_COMMIT:  cmd.l1.commit = 1'b1;
      S_L2W_INIT: begin
        cmd.l2.init    = 1'b1;
        cmd.l2_wr_pass = 1'b1;
      end
      S_L2W_WAIT:   cmd.l2_wr_pass = 1'b1;
      S_L2W_EVAL: begin
        cmd.l2.eval    = 1'b1;
        cmd.l2_wr_pass = 1'b1;
      end
      S_L2W_COMMIT: begin
        cmd.l2.commit  = 1'b1;
        cmd.l2_wr_pass = 1'b1;
      end
      S_L2R_INIT:   cmd.l2.init = 1'b1;
      S_L2R_EVAL:   cmd.l2.eval = 1'b1;
      S_L2R_COMMIT: cmd.l2.commit = 1'b1;
      S_DONE:       cmd.load_out = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_L1_WAIT))
    else $error("accepted word did not start a lookup");
  a_l2w_after_l1: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_L2W_INIT) |-> ($past(state_r) == S_L1_COMMIT && $past(sts.l1.vic_dirty)))
    else $error("victim write without dirty victim");
`endif

endmodule

>>> sv/two_level_cache_tag_controller_unit.sv
`timescale 1ns / 1ps
// Tag controller for a write-back, write-allocate L1 with an optional L2 behind it.
// Each level keeps its lines in a tag RAM and scans the ways of a set one at a time
// through the RAM's registered read port, stopping at a hit. An access runs the L1
// lookup, then on an L1 miss with L2 enabled an L2 victim write (dirty victim only)
// and the L2 miss read, then hands off the result; a new word is accepted while the
// last result waits. After reset a clearing pass sweeps every entry of both RAMs;
// no access is taken during it, configuration writes are.
// in_tdata: address[31:0]. in_tuser: op (0 read, 1 write).
module two_level_cache_tag_controller_unit import tlc_pkg::*; #(
  parameter int L1_MAX_SETS = 256,
  parameter int L2_MAX_SETS = 1024,
  parameter int MAX_WAYS    = 32,
  parameter int ADDR_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,  // address
  input  logic [0:0]            in_tuser,  // op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // l1_hit, l1_writeback, l2_read_done, l2_read_hit, l2_write_done, l2_write_hit,
  // l2_writebacks[1:0], mem_transfers[2:0], zero fill
  output logic [OUT_W-1:0]      out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  tlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_tvalid & in_tready),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd),
    .sts       (sts)
  );

  tlc_datapath #(
    .L1_SETS (L1_MAX_SETS),
    .L2_SETS (L2_MAX_SETS),
    .MAXW    (MAX_WAYS),
    .ADDR_W  (ADDR_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_addr  (in_tdata),
    .in_op    (in_tuser[0]),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_idx  (cfg_index),
    .cfg_val  (cfg_data),
    .out_data (out_tdata)
  );

endmodule

>>> test/tb_two_level_cache_tag_controller_unit.sv
`timescale 1ns / 1ps
module tb_two_level_cache_tag_controller_unit import tlc_pkg::*; ();

  localparam int L1_SETS   = 256;
  localparam int L2_SETS   = 1024;
  localparam int WAYS      = 32;
  localparam int LIMIT     = 3000000;
  localparam bit OP_READ   = 1'b0;
  localparam bit OP_WRITE  = 1'b1;

  typedef struct packed {
    logic [4:0] zero;
    logic [2:0] traffic;
    logic [1:0] l2_wbs;
    logic       l2_wr_hit;
    logic       l2_wr_done;
    logic       l2_rd_hit;
    logic       l2_rd_done;
    logic       l1_wb;
    logic       l1_hit;
  } access_res_t;

  typedef struct {
    bit          op;
    logic [31:0] addr;
    bit          known;
    access_res_t res;
  } access_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  two_level_cache_tag_controller_unit u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // tag store mirror
  bit          l1_v [L1_SETS*WAYS];
  bit          l1_d [L1_SETS*WAYS];
  logic [31:0] l1_t [L1_SETS*WAYS];
  int unsigned l1_s [L1_SETS*WAYS];
  bit          l2_v [L2_SETS*WAYS];
  bit          l2_d [L2_SETS*WAYS];
  logic [31:0] l2_t [L2_SETS*WAYS];
  int unsigned l2_s [L2_SETS*WAYS];
  int unsigned l1_cnt = 0, l2_cnt = 0;

  bit       m_fifo = 0, m_l2en = 0;
  int       m_off = 5, m_l1ib = 6, m_l1w = 2, m_l2ib = 8, m_l2w = 4;

  access_res_t pending_res[$];
  int errors = 0;
  int n_seen = 0;
  longint cycles = 0;

  function automatic int clip_ib(int req, int maxb);
    return (req > maxb) ? maxb : req;
  endfunction

  function automatic int clip_ways(int w);
    if (w == 0) return 1;
    if (w > WAYS) return WAYS;
    return w;
  endfunction

  function automatic int unsigned bump(int unsigned c);
    return (c == 32'hFFFF_FFFF) ? c : c + 1;
  endfunction

  function automatic bit l2_touch(logic [31:0] a, bit wr, inout int wbs);
    int ib, ways, base, v, w;
    logic [31:0] set, tg;
    ib = clip_ib(m_l2ib, 10);
    ways = clip_ways(m_l2w);
    set = (a >> m_off) & ((32'd1 << ib) - 1);
    tg = 32'(64'(a) >> (m_off + ib));
    base = set * WAYS;
    l2_cnt = bump(l2_cnt);
    for (w = 0; w < ways; w++)
      if (l2_v[base+w] && l2_t[base+w] == tg) begin
        if (!m_fifo) l2_s[base+w] = l2_cnt;
        if (wr) l2_d[base+w] = 1;
        return 1;
      end
    v = -1;
    for (w = 0; w < ways && v < 0; w++)
      if (!l2_v[base+w]) v = w;
    if (v < 0) begin
      v = 0;
      for (w = 1; w < ways; w++)
        if (l2_s[base+w] < l2_s[base+v]) v = w;
    end
    v = base + v;
    if (l2_v[v] && l2_d[v]) wbs++;
    l2_t[v] = tg;
    l2_s[v] = l2_cnt;
    l2_v[v] = 1;
    l2_d[v] = wr;
    return 0;
  endfunction

  function automatic access_res_t cache_access(bit op, logic [31:0] a);
    access_res_t r;
    int ib, ways, base, v, w, h, wbs, trf;
    logic [31:0] set, tg, offv;
    logic [63:0] back;
    r = '0;
    wbs = 0;
    ib = clip_ib(m_l1ib, 8);
    ways = clip_ways(m_l1w);
    set = (a >> m_off) & ((32'd1 << ib) - 1);
    tg = 32'(64'(a) >> (m_off + ib));
    offv = a & ((32'd1 << m_off) - 1);
    base = set * WAYS;
    l1_cnt = bump(l1_cnt);
    h = -1;
    for (w = 0; w < ways && h < 0; w++)
      if (l1_v[base+w] && l1_t[base+w] == tg) h = w;
    if (h >= 0) begin
      r.l1_hit = 1;
      if (!m_fifo) l1_s[base+h] = l1_cnt;
      if (op) l1_d[base+h] = 1;
    end else begin
      v = -1;
      for (w = 0; w < ways && v < 0; w++)
        if (!l1_v[base+w]) v = w;
      if (v < 0) begin
        v = 0;
        for (w = 1; w < ways; w++)
          if (l1_s[base+w] < l1_s[base+v]) v = w;
      end
      v = base + v;
      if (l1_v[v] && l1_d[v]) begin
        r.l1_wb = 1;
        if (m_l2en) begin
          back = ((((64'(l1_t[v]) << ib) | 64'(set)) << m_off) | 64'(offv));
          r.l2_wr_done = 1;
          r.l2_wr_hit = l2_touch(back[31:0], 1, wbs);
        end
      end
      if (m_l2en) begin
        r.l2_rd_done = 1;
        r.l2_rd_hit = l2_touch(a, 0, wbs);
      end
      l1_t[v] = tg;
      l1_s[v] = l1_cnt;
      l1_v[v] = 1;
      l1_d[v] = op;
    end
    if (m_l2en)
      trf = (r.l2_rd_done && !r.l2_rd_hit) + (r.l2_wr_done && !r.l2_wr_hit) + wbs;
    else
      trf = !r.l1_hit + r.l1_wb;
    r.l2_wbs = wbs[1:0];
    r.traffic = trf[2:0];
    return r;
  endfunction

  task automatic idle_gap();
    int r, n;
    r = $urandom_range(0, 99);
    n = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_word(bit op, logic [31:0] a, bit known, access_res_t res);
    access_res_t p;
    idle_gap();
    in_tvalid <= 1'b1;
    in_tdata <= a;
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    p = cache_access(op, a);
    pending_res.push_back(known ? res : p);
  endtask

  task automatic drain();
    @(posedge clk);
    in_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FIFO_MODE:   m_fifo = val[0];
      CFG_OFFSET_BITS: m_off = val & 7;
      CFG_L1_INDEX:    m_l1ib = val & 15;
      CFG_L1_WAYS:     m_l1w = val & 63;
      CFG_L2_ENABLE:   m_l2en = val[0];
      CFG_L2_INDEX:    m_l2ib = val & 15;
      CFG_L2_WAYS:     m_l2w = val & 63;
      default: ;
    endcase
  endtask

  task automatic run_random(int n);
    logic [31:0] tags [12];
    logic [63:0] a;
    int i, ib;
    for (i = 0; i < 12; i++) tags[i] = (i < 6) ? i : $urandom;
    tags[11] = 32'hFFFF_FFFF;
    ib = clip_ib(m_l1ib, 8);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) a = $urandom;
      else
        a = (64'(tags[$urandom_range(0, 11)]) << (m_off + ib))
          | (64'($urandom_range(0, 3)) << m_off)
          | 64'($urandom & ((32'd1 << m_off) - 1));
      send_word(1'($urandom_range(0, 1)), a[31:0], 1'b0, '0);
    end
  endtask

  task automatic set_all(int f, int o, int i1, int w1, int e, int i2, int w2);
    cfg_write(CFG_FIFO_MODE, f);
    cfg_write(CFG_OFFSET_BITS, o);
    cfg_write(CFG_L1_INDEX, i1);
    cfg_write(CFG_L1_WAYS, w1);
    cfg_write(CFG_L2_ENABLE, e);
    cfg_write(CFG_L2_INDEX, i2);
    cfg_write(CFG_L2_WAYS, w2);
    cfg_valid <= 1'b0;
  endtask

  access_row_t rows [12] = '{
    '{OP_READ,  32'h0000_0000, 1, 16'h0100},
    '{OP_READ,  32'h0000_0000, 1, 16'h0001},
    '{OP_WRITE, 32'h0000_001F, 1, 16'h0001},
    '{OP_READ,  32'hFFFF_FFFF, 1, 16'h0100},
    '{OP_WRITE, 32'h0000_0800, 1, 16'h0100},
    '{OP_READ,  32'h0000_1000, 1, 16'h0202},
    '{OP_READ,  32'h0000_0000, 1, 16'h0202},
    '{OP_WRITE, 32'hFFFF_FFE0, 1, 16'h0001},
    '{OP_WRITE, 32'h0000_1800, 0, 16'h0000},
    '{OP_READ,  32'h0000_2000, 0, 16'h0000},
    '{OP_WRITE, 32'h7FFF_FFFF, 0, 16'h0000},
    '{OP_READ,  32'h8000_0000, 0, 16'h0000}
  };

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (rows[k]) send_word(rows[k].op, rows[k].addr, rows[k].known, rows[k].res);
    drain();
    set_all(0, 5, 6, 2, 1, 8, 4);
    run_random(280);
    drain();
    set_all(1, 0, 0, 1, 1, 0, 1);
    run_random(250);
    drain();
    set_all(0, 7, 15, 63, 1, 15, 63);
    run_random(120);
    drain();
    set_all(1, 3, 2, 4, 1, 3, 8);
    run_random(250);
    drain();
    set_all(0, 2, 1, 0, 1, 2, 0);
    run_random(200);
    drain();
    set_all(0, 4, 3, 3, 0, 10, 2);
    run_random(150);
    drain();
    set_all($urandom_range(0, 1), $urandom_range(0, 7), $urandom_range(0, 8),
            $urandom_range(1, 6), 1, $urandom_range(0, 10), $urandom_range(1, 6));
    run_random(250);
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int hold_left, r;
    bit held;
    hold_left = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (pending_res.size() == 0) begin
          errors++;
          $display("%0t unexpected word: got %h", $time, out_tdata);
        end else begin
          access_res_t e, g;
          e = pending_res.pop_front();
          g = out_tdata;
          if (g !== e) begin
            errors++;
            $display("%0t mismatch: expected %h got %h", $time, e, g);
          end
        end
        n_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!held && n_seen >= 60) begin
        held = 1;
        hold_left = 400;
        out_tready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) hold_left = $urandom_range(10, 40);
        out_tready <= (r >= 20);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
